FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_CTRL      = 3'd2;
  localparam logic [2:0] ST_BAD_ESC   = 3'd3;
  localparam logic [2:0] ST_BAD_HEX   = 3'd4;
  localparam logic [2:0] ST_NO_LOW    = 3'd5;
  localparam logic [2:0] ST_LOW_RANGE = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // One queued job: a status, the number of bytes minus one and the value.
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  len;
    logic [20:0] cp;
  } jsu_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jsu_qstat_t;

endpackage

FILE: design/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels carrying raw input bytes and decoded results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts string body bytes, tracks escapes and surrogates, and queues jobs.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output jsu_entry_t push_entry
);

  typedef enum logic [2:0] {
    M_BODY, M_ESC, M_HEX, M_LOWBS, M_LOWU, M_LOWHEX
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  hh_r, hh_nxt;

  logic        fire;
  logic [7:0]  b;
  logic        is_hex;
  logic [3:0]  dig;
  logic [15:0] v;
  logic [20:0] pair_cp;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign v           = {acc_r, dig};
  assign pair_cp     = {1'b0, hh_r, v[9:0]} + 21'h10000;

  always_comb begin
    is_hex = 1'b1;
    dig    = 4'd0;
    priority if (b >= 8'h30 && b <= 8'h39) begin
      dig = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dig = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      dig = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    hh_nxt     = hh_r;
    push       = 1'b0;
    push_entry = '{status: ST_DATA, len: 2'd0, cp: '0};
    if (fire) begin
      unique case (mode_r)
        M_BODY: begin
          priority if (b == CH_QUOTE) begin
            push = 1'b1;
            push_entry.status = ST_END;
          end else if (b < CH_SPACE) begin
            push = 1'b1;
            push_entry.status = ST_CTRL;
          end else if (b == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            push = 1'b1;
            push_entry.cp = {13'd0, b};
          end
        end
        M_ESC: begin
          mode_nxt = M_BODY;
          cnt_nxt  = 2'd0;
          acc_nxt  = '0;
          push     = 1'b1;
          unique case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_entry.cp = {13'd0, b};
            CH_B: push_entry.cp = 21'h08;
            CH_F: push_entry.cp = 21'h0C;
            CH_N: push_entry.cp = 21'h0A;
            CH_R: push_entry.cp = 21'h0D;
            CH_T: push_entry.cp = 21'h09;
            CH_U: begin
              push     = 1'b0;
              mode_nxt = M_HEX;
            end
            default: push_entry.status = ST_BAD_ESC;
          endcase
        end
        M_HEX, M_LOWHEX: begin
          if (!is_hex) begin
            push              = 1'b1;
            push_entry.status = ST_BAD_HEX;
            mode_nxt          = M_BODY;
            cnt_nxt           = 2'd0;
            acc_nxt           = '0;
          end else if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
            acc_nxt = {acc_r[7:0], dig};
          end else begin
            cnt_nxt  = 2'd0;
            acc_nxt  = '0;
            mode_nxt = M_BODY;
            if (mode_r == M_HEX) begin
              if (v[15:10] == 6'b110110) begin
                hh_nxt   = v[9:0];
                mode_nxt = M_LOWBS;
              end else begin
                push          = 1'b1;
                push_entry.cp = {5'd0, v};
                priority if (v < 16'h0080) begin
                  push_entry.len = 2'd0;
                end else if (v < 16'h0800) begin
                  push_entry.len = 2'd1;
                end else begin
                  push_entry.len = 2'd2;
                end
              end
            end else begin
              push = 1'b1;
              if (v[15:10] != 6'b110111) begin
                push_entry.status = ST_LOW_RANGE;
              end else begin
                push_entry.cp  = pair_cp;
                push_entry.len = 2'd3;
              end
            end
          end
        end
        M_LOWBS: begin
          if (b != CH_BSLASH) begin
            push              = 1'b1;
            push_entry.status = ST_NO_LOW;
            mode_nxt          = M_BODY;
          end else begin
            mode_nxt = M_LOWU;
          end
        end
        M_LOWU: begin
          cnt_nxt = 2'd0;
          acc_nxt = '0;
          if (b != CH_U) begin
            push              = 1'b1;
            push_entry.status = ST_NO_LOW;
            mode_nxt          = M_BODY;
          end else begin
            mode_nxt = M_LOWHEX;
          end
        end
        default: begin
          mode_nxt = M_BODY;
          cnt_nxt  = 2'd0;
          acc_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BODY;
      cnt_r  <= 2'd0;
      acc_r  <= '0;
      hh_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hh_r   <= hh_nxt;
    end
  end

endmodule

FILE: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  jsu_entry_t push_entry,
  input  logic       pop,
  output jsu_entry_t head,
  output jsu_qstat_t qstat
);

  jsu_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign head        = mem[rd_ptr_r];
  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued jobs into results, one UTF-8 byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  jsu_entry_t head,
  input  logic       head_valid,
  output logic       pop,
  jsu_out_if.source  out_ch
);

  logic [1:0] idx_r;
  logic       ov_r;
  logic [7:0] obyte_r;
  logic [2:0] ostat_r;
  logic       olast_r;

  logic       load;
  logic       fin;
  logic [7:0] sel_byte;

  assign load = !ov_r || out_ch.ready;
  assign fin  = (idx_r == head.len);
  assign pop  = load && head_valid && fin;

  always_comb begin
    unique case (head.len)
      2'd0: sel_byte = head.cp[7:0];
      2'd1: begin
        unique case (idx_r)
          2'd0:    sel_byte = {3'b110, head.cp[10:6]};
          default: sel_byte = {2'b10, head.cp[5:0]};
        endcase
      end
      2'd2: begin
        unique case (idx_r)
          2'd0:    sel_byte = {4'b1110, head.cp[15:12]};
          2'd1:    sel_byte = {2'b10, head.cp[11:6]};
          default: sel_byte = {2'b10, head.cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx_r)
          2'd0:    sel_byte = {5'b11110, head.cp[20:18]};
          2'd1:    sel_byte = {2'b10, head.cp[17:12]};
          2'd2:    sel_byte = {2'b10, head.cp[11:6]};
          default: sel_byte = {2'b10, head.cp[5:0]};
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      ov_r <= head_valid;
      if (head_valid) begin
        idx_r <= fin ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      obyte_r <= sel_byte;
      ostat_r <= head.status;
      olast_r <= fin;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = obyte_r;
  assign out_ch.status   = ostat_r;
  assign out_ch.last     = olast_r;

endmodule

FILE: design/json_string_unescape_utf8.sv
// Path: a completed job is written into the job queue, then into the back end's output register.
// Throughput: one input byte per cycle while the job queue is not full; the back end
// emits one result per cycle while out_ch.ready is high, so a multi-byte code point
// holds it while a four-entry job queue lets the front end keep taking bytes.
// Reset: synchronous, active low; clears the escape state, queue and output.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper producing UTF-8 bytes and status results.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic       push;
  logic       pop;
  jsu_entry_t push_entry;
  jsu_entry_t head;
  jsu_qstat_t qstat;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (qstat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("Job queued while the queue is full.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("Job removed from an empty queue.");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_DATA) |-> (out_ch.last && out_ch.out_byte == 8'd0))
    else $error("Status result without last flag or with a non-zero byte.");

endmodule
